// ----- rtl/prvs_pkg.sv -----
// ----------------------------------------------------------------------------
// prvs_pkg
// Shared types and constants for the posting record varint scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package prvs_pkg;

  // Configuration port geometry
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_SKIP  = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_MINTF = 2'd2;

  // Result status codes
  localparam logic ST_QUALIFY   = 1'b0;
  localparam logic ST_MALFORMED = 1'b1;

  // Varint byte layout
  localparam logic [7:0] VARINT_MORE = 8'h80;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_PREFIX = 4'b0001,
    PH_DOCID  = 4'b0010,
    PH_FREQ   = 4'b0100,
    PH_SKIP   = 4'b1000
  } phase_t;

  // Configuration register set
  typedef struct packed {
    logic [23:0] skip_qualifying;
    logic [23:0] report_limit;
    logic [31:0] min_term_freq;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic        status;
    logic [31:0] body_length;
    logic [23:0] body_offset;
    logic [31:0] term_freq;
    logic [31:0] doc_id;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/prvs_cfg.sv -----
// ----------------------------------------------------------------------------
// prvs_cfg
// APB-style register file: record skip count, report limit, minimum frequency.
// ----------------------------------------------------------------------------
`default_nettype none

module prvs_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [prvs_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [prvs_pkg::DATA_W-1:0]   pwdata,
  output logic      [prvs_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output prvs_pkg::cfg_t                     cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.skip_qualifying <= '0;
      cfg.report_limit    <= '1;
      cfg.min_term_freq   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        prvs_pkg::REG_SKIP:  cfg.skip_qualifying <= pwdata[23:0];
        prvs_pkg::REG_LIMIT: cfg.report_limit    <= pwdata[23:0];
        prvs_pkg::REG_MINTF: cfg.min_term_freq   <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      prvs_pkg::REG_SKIP:  prdata = {8'd0, cfg.skip_qualifying};
      prvs_pkg::REG_LIMIT: prdata = {8'd0, cfg.report_limit};
      prvs_pkg::REG_MINTF: prdata = cfg.min_term_freq;
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/prvs_core.sv -----
// ----------------------------------------------------------------------------
// prvs_core
// Record parser state: length prefix, two varints, body skip and qualification.
// ----------------------------------------------------------------------------
`default_nettype none

module prvs_core #(
  parameter longint unsigned MAX_BUFFER_BYTES = 64'd16777216
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       data_byte,
  input  wire logic             last_byte,
  input  wire prvs_pkg::cfg_t   cfg,
  output logic                  res_valid,
  output prvs_pkg::result_t     res
);

  localparam int POS_W = $clog2(MAX_BUFFER_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_BUFFER_BYTES - 64'd1);

  // State
  prvs_pkg::phase_t  phase, phase_next;
  logic [1:0]        pfx_cnt, pfx_cnt_next;
  logic [31:0]       len_acc, len_acc_next;
  logic [31:0]       did_acc, did_acc_next;
  logic [31:0]       frq_acc, frq_acc_next;
  logic [31:0]       remain, remain_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [POS_W-1:0]  bstart, bstart_next;
  logic [24:0]       qual_cnt, qual_cnt_next;

  logic [POS_W-1:0]  pos_inc;
  logic [24:0]       win_end;
  logic              win_open;
  logic              more;
  logic              malformed;
  logic              qualify_hit;

  assign pos_inc  = (pos == POS_LAST) ? '0 : pos + POS_W'(1);
  assign win_end  = {1'b0, cfg.skip_qualifying} + {1'b0, cfg.report_limit};
  assign more     = (data_byte & prvs_pkg::VARINT_MORE) != 8'd0;

  // Next state for one byte
  always_comb begin
    phase_next    = phase;
    pfx_cnt_next  = pfx_cnt;
    len_acc_next  = len_acc;
    did_acc_next  = did_acc;
    frq_acc_next  = frq_acc;
    remain_next   = remain;
    bstart_next   = bstart;
    qual_cnt_next = qual_cnt;
    malformed     = 1'b0;
    qualify_hit   = 1'b0;

    unique case (phase)
      prvs_pkg::PH_PREFIX: begin
        len_acc_next = {len_acc[23:0], data_byte};
        if (pfx_cnt == 2'd3) begin
          pfx_cnt_next = 2'd0;
          remain_next  = len_acc_next;
          bstart_next  = pos_inc;
          did_acc_next = '0;
          frq_acc_next = '0;
          if (len_acc_next == 32'd0) begin
            malformed = 1'b1;
          end else begin
            phase_next = prvs_pkg::PH_DOCID;
          end
        end else begin
          pfx_cnt_next = pfx_cnt + 2'd1;
        end
      end
      prvs_pkg::PH_DOCID: begin
        remain_next  = remain - 32'd1;
        did_acc_next = {did_acc[24:0], data_byte[6:0]};
        if (!more) begin
          phase_next = prvs_pkg::PH_FREQ;
        end
        if (remain_next == 32'd0) begin
          malformed  = 1'b1;
          phase_next = prvs_pkg::PH_PREFIX;
        end
      end
      prvs_pkg::PH_FREQ: begin
        remain_next  = remain - 32'd1;
        frq_acc_next = {frq_acc[24:0], data_byte[6:0]};
        if (!more) begin
          if (frq_acc_next >= cfg.min_term_freq) begin
            priority if (qual_cnt < {1'b0, cfg.skip_qualifying}) begin
              qual_cnt_next = qual_cnt + 25'd1;
            end else if (qual_cnt < win_end) begin
              qual_cnt_next = qual_cnt + 25'd1;
              qualify_hit   = 1'b1;
            end else begin
            end
          end
          phase_next = (remain_next == 32'd0) ? prvs_pkg::PH_PREFIX : prvs_pkg::PH_SKIP;
        end else if (remain_next == 32'd0) begin
          malformed  = 1'b1;
          phase_next = prvs_pkg::PH_PREFIX;
        end
      end
      prvs_pkg::PH_SKIP: begin
        remain_next = remain - 32'd1;
        if (remain_next == 32'd0) begin
          phase_next = prvs_pkg::PH_PREFIX;
        end
      end
      default: begin
        phase_next = prvs_pkg::PH_PREFIX;
      end
    endcase

    pos_next = pos_inc;
  end

  // Result for this byte, registered by the top level
  assign win_open  = qual_cnt < win_end;
  assign res_valid = step & (qualify_hit | (malformed & win_open));

  always_comb begin
    res.status      = malformed ? prvs_pkg::ST_MALFORMED : prvs_pkg::ST_QUALIFY;
    res.doc_id      = malformed ? 32'd0 : did_acc_next;
    res.term_freq   = malformed ? 32'd0 : frq_acc_next;
    res.body_offset = 24'(bstart_next);
    res.body_length = len_acc_next;
  end

  // State registers; end of buffer returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      phase    <= prvs_pkg::PH_PREFIX;
      pfx_cnt  <= '0;
      len_acc  <= '0;
      did_acc  <= '0;
      frq_acc  <= '0;
      remain   <= '0;
      pos      <= '0;
      bstart   <= '0;
      qual_cnt <= '0;
    end else if (step) begin
      phase    <= phase_next;
      pfx_cnt  <= pfx_cnt_next;
      len_acc  <= len_acc_next;
      did_acc  <= did_acc_next;
      frq_acc  <= frq_acc_next;
      remain   <= remain_next;
      pos      <= pos_next;
      bstart   <= bstart_next;
      qual_cnt <= qual_cnt_next;
    end
  end

  // Checks
  a_pfx_only_in_prefix: assert property (@(posedge clk) disable iff (rst)
    (pfx_cnt != 2'd0) |-> (phase == prvs_pkg::PH_PREFIX))
    else $error("prefix byte count set outside prefix phase");

  a_body_left: assert property (@(posedge clk) disable iff (rst)
    (phase != prvs_pkg::PH_PREFIX) |-> (remain != 32'd0))
    else $error("body phase with no body bytes left");

  a_qualify_from_freq: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == prvs_pkg::ST_QUALIFY) |-> (phase == prvs_pkg::PH_FREQ))
    else $error("qualifying result outside frequency phase");

endmodule

`default_nettype wire

// ----- rtl/posting_record_varint_scanner.sv -----
// ----------------------------------------------------------------------------
// posting_record_varint_scanner
// Parses length-prefixed posting records from a byte stream and reports
// qualifying records (id, frequency, offset, length) or malformed ones.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------
//  s_       | in  | s_tvalid/s_tready  | tdata: data_byte, tlast: last_byte
//  m_       | out | m_tvalid/m_tready  | tdata: doc_id..body_length, tuser: status
//  apb      | in  | psel/penable       | skip, report limit, min frequency
//
//  One byte per cycle sustained while m_ is not stalled; a result is offered the
//  cycle after its byte leaves the input register.
//  The input register feeds the parser logic; the result register holds one item.
//  The parser advances when the input register holds a byte and the result register is empty or being drained.
//  Synchronous reset clears all parser state; registers return to defaults.
//  A stall on m_ backs up through the input register into s_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module posting_record_varint_scanner #(
  parameter longint unsigned MAX_BUFFER_BYTES = 64'd16777216
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // byte stream in
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,   // [7:0] data_byte
  input  wire logic                          s_tlast,
  // records out
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [119:0]                  m_tdata,   // [31:0] doc_id, [63:32] term_freq,
                                                        // [87:64] body_offset,
                                                        // [119:88] body_length
  output logic                               m_tuser,   // [0] status
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [prvs_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [prvs_pkg::DATA_W-1:0]   pwdata,
  output logic      [prvs_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  prvs_pkg::cfg_t    cfg;
  prvs_pkg::result_t res;
  prvs_pkg::result_t out_q;
  logic              res_valid;

  logic       stg_valid;
  logic [7:0] stg_byte;
  logic       stg_last;
  logic       adv;

  // Parser steps when the input register holds a byte and the output register can take a result
  assign adv      = stg_valid & (~m_tvalid | m_tready);
  assign s_tready = ~stg_valid | adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (s_tready) begin
      stg_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      stg_byte <= s_tdata;
      stg_last <= s_tlast;
    end
  end

  prvs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  prvs_core #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (adv),
    .data_byte (stg_byte),
    .last_byte (stg_last),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_q <= res;
    end
  end

  assign m_tdata = {out_q.body_length, out_q.body_offset, out_q.term_freq, out_q.doc_id};
  assign m_tuser = out_q.status;

  // Checks
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (stg_valid && !adv) |=> (stg_valid && $stable(stg_byte) && $stable(stg_last)))
    else $error("input register lost a byte while stalled");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !adv)
    else $error("parser stepped over an undelivered result");

endmodule

`default_nettype wire
